// File: rtl/grm_pkg.sv
package grm_pkg;

    localparam int ROOT_BITS = 32;
    localparam int CNT_BITS  = $clog2(ROOT_BITS);
    localparam int STEP_BITS = 3;

    typedef logic [ROOT_BITS-1:0] root_t;

    typedef enum logic [2:0] {
        MODE_IDENT     = 3'd0,
        MODE_INVERSE   = 3'd1,
        MODE_NEGATE    = 3'd2,
        MODE_ORDER3A   = 3'd3,
        MODE_ORDER3B   = 3'd4,
        MODE_ORDER4    = 3'd5,
        MODE_ORDER6    = 3'd6,
        MODE_IDENT_ALT = 3'd7
    } mode_t;

    // finishing micro-ops on the work register
    typedef enum logic [2:0] {
        MOP_FIX,
        MOP_SIGN,
        MOP_NEG,
        MOP_ADD_W,
        MOP_ADD_IV,
        MOP_ADD_ONE,
        MOP_ADD_TWO,
        MOP_END
    } mop_t;

    typedef struct packed {
        logic load;
        logic align;
        logic sub;
        logic euclid;
        logic prep;
        logic fin;
        mop_t mop;
        logic out_load;
    } grm_cmd_t;

    typedef struct packed {
        logic need_reduce;
        logic direct;
        logic shift_ok;
        logic last;
        logic rem_zero;
    } grm_status_t;

    function automatic logic [2:0] order_of(mode_t m);
        logic [2:0] o;
        case (m)
            MODE_INVERSE: o = 3'd2;
            MODE_NEGATE:  o = 3'd2;
            MODE_ORDER3A: o = 3'd3;
            MODE_ORDER3B: o = 3'd3;
            MODE_ORDER4:  o = 3'd4;
            MODE_ORDER6:  o = 3'd6;
            default:      o = 3'd1;
        endcase
        return o;
    endfunction

    // op sequence applied after the gcd loop, one op per cycle
    function automatic mop_t fin_op(mode_t m, logic [STEP_BITS-1:0] step);
        mop_t op;
        op = MOP_END;
        if (step == 3'd0) begin
            op = MOP_FIX;
        end else if (step == 3'd1) begin
            op = MOP_SIGN;
        end else begin
            case (m)
                MODE_ORDER3A:
                begin
                    case (step)
                        3'd2:    op = MOP_NEG;
                        3'd3:    op = MOP_ADD_ONE;
                        default: op = MOP_END;
                    endcase
                end
                MODE_ORDER3B:
                begin
                    case (step)
                        3'd2:    op = MOP_ADD_ONE;
                        3'd3:    op = MOP_NEG;
                        default: op = MOP_END;
                    endcase
                end
                MODE_ORDER4:
                begin
                    case (step)
                        3'd2:    op = MOP_ADD_W;
                        3'd3:    op = MOP_ADD_ONE;
                        3'd4:    op = MOP_NEG;
                        default: op = MOP_END;
                    endcase
                end
                MODE_ORDER6:
                begin
                    case (step)
                        3'd2:    op = MOP_ADD_W;
                        3'd3:    op = MOP_ADD_IV;
                        3'd4:    op = MOP_ADD_TWO;
                        3'd5:    op = MOP_NEG;
                        default: op = MOP_END;
                    endcase
                end
                default: op = MOP_END;
            endcase
        end
        return op;
    endfunction

endpackage

// File: rtl/grm_if.sv
interface grm_root_if;
    import grm_pkg::*;

    logic  valid;
    logic  ready;
    root_t root;
    root_t modulus;

    modport source (output valid, output root, output modulus, input ready);
    modport sink   (input valid, input root, input modulus, output ready);
endinterface

interface grm_image_if;
    import grm_pkg::*;

    logic       valid;
    logic       ready;
    root_t      image_root;
    logic [2:0] orbit_order;
    logic       not_invertible;

    modport source (output valid, output image_root, output orbit_order,
                    output not_invertible, input ready);
    modport sink   (input valid, input image_root, input orbit_order,
                    input not_invertible, output ready);
endinterface

// File: rtl/grm_datapath.sv
module grm_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  grm_pkg::root_t        root,
    input  grm_pkg::root_t        modulus,
    input  logic [2:0]            mode,
    input  grm_pkg::grm_cmd_t     cmd,
    output grm_pkg::grm_status_t  st,
    output grm_pkg::root_t        image_root,
    output logic [2:0]            orbit_order,
    output logic                  not_invertible
);
    import grm_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(ROOT_BITS - 1);

    root_t x_reg, p_reg, ra_reg, rb_reg, sa_reg, sb_reg, d_reg, sd_reg, w_reg, iv_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic odd_reg, bad_reg;
    root_t img_out_reg;
    logic [2:0] order_out_reg;
    logic bad_out_reg;

    mode_t m;
    logic bypass, p_small, inf, x_zero, x_one;
    root_t p_m1, p_m2, x_m1;
    logic direct;
    root_t dir_val, inv_arg;

    logic [ROOT_BITS:0] d_dbl;
    logic shift_ok, ge;
    root_t ra_sub, sa_add;

    root_t addb, two, neg_w, fix_val, sign_val, add_res, alu_res;
    logic [ROOT_BITS:0] sum;

    assign m       = mode_t'(mode);
    assign bypass  = m inside {MODE_IDENT, MODE_IDENT_ALT};
    assign p_small = (p_reg[ROOT_BITS-1:1] == '0);
    assign inf     = (x_reg == p_reg);
    assign x_zero  = (x_reg == '0);
    assign x_one   = (x_reg == root_t'(1));
    assign p_m1    = p_reg - root_t'(1);
    assign p_m2    = p_reg - root_t'(2);
    assign x_m1    = x_reg - root_t'(1);

    // image for the pole, infinity and non-inverting cases
    always_comb
    begin
        direct  = 1'b1;
        dir_val = x_reg;
        inv_arg = x_reg;
        if (bypass) begin
            dir_val = x_reg;
        end else if (p_small) begin
            dir_val = '0;
        end else begin
            case (m)
                MODE_INVERSE:
                begin
                    if (x_zero)   dir_val = p_reg;
                    else if (inf) dir_val = '0;
                    else          direct  = 1'b0;
                end
                MODE_NEGATE:
                begin
                    dir_val = (inf || x_zero) ? x_reg : p_reg - x_reg;
                end
                MODE_ORDER3A:
                begin
                    if (x_zero)   dir_val = p_reg;
                    else if (inf) dir_val = root_t'(1);
                    else          direct  = 1'b0;
                end
                MODE_ORDER3B:
                begin
                    if (x_zero)   dir_val = p_reg;
                    else if (inf) dir_val = p_m1;
                    else          direct  = 1'b0;
                end
                MODE_ORDER4:
                begin
                    inv_arg = x_zero ? p_m1 : x_m1;
                    if (x_one)    dir_val = p_reg;
                    else if (inf) dir_val = p_m1;
                    else          direct  = 1'b0;
                end
                MODE_ORDER6:
                begin
                    inv_arg = x_zero ? p_m1 : x_m1;
                    if (x_one)    dir_val = p_reg;
                    else if (inf) dir_val = p_m2;
                    else          direct  = 1'b0;
                end
                default: dir_val = x_reg;
            endcase
        end
    end

    // shift-subtract divider shared by the reduction and every gcd quotient
    assign d_dbl    = {d_reg, 1'b0};
    assign shift_ok = (d_dbl <= {1'b0, ra_reg});
    assign ge       = (ra_reg >= d_reg);
    assign ra_sub   = ge ? ra_reg - d_reg : ra_reg;
    assign sa_add   = ge ? sa_reg + sd_reg : sa_reg;

    assign st.need_reduce = !bypass && !p_small && (x_reg > p_reg);
    assign st.direct      = direct;
    assign st.shift_ok    = shift_ok;
    assign st.last        = (cnt_reg == '0);
    assign st.rem_zero    = (ra_sub == '0);

    // modular ALU for the finishing ops
    assign two     = (p_reg == root_t'(2)) ? '0 : root_t'(2);
    assign neg_w   = (w_reg == '0) ? '0 : p_reg - w_reg;
    assign fix_val = (sa_reg >= p_reg) ? sa_reg - p_reg : sa_reg;
    assign sign_val = odd_reg ? w_reg : neg_w;

    always_comb
    begin
        case (cmd.mop)
            MOP_ADD_W:   addb = w_reg;
            MOP_ADD_IV:  addb = iv_reg;
            MOP_ADD_ONE: addb = root_t'(1);
            MOP_ADD_TWO: addb = two;
            default:     addb = '0;
        endcase
    end

    assign sum     = {1'b0, w_reg} + {1'b0, addb};
    assign add_res = (sum >= {1'b0, p_reg}) ? root_t'(sum - {1'b0, p_reg})
                                            : sum[ROOT_BITS-1:0];

    always_comb
    begin
        case (cmd.mop)
            MOP_FIX:  alu_res = fix_val;
            MOP_SIGN: alu_res = sign_val;
            MOP_NEG:  alu_res = neg_w;
            MOP_END:  alu_res = w_reg;
            default:  alu_res = add_res;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            x_reg   <= root;
            p_reg   <= modulus;
            ra_reg  <= root;
            d_reg   <= modulus;
            sd_reg  <= '0;
            cnt_reg <= '0;
        end else if (cmd.align) begin
            if (shift_ok) begin
                d_reg   <= d_dbl[ROOT_BITS-1:0];
                sd_reg  <= sd_reg << 1;
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
        end else if (cmd.sub) begin
            if (cnt_reg != '0) begin
                ra_reg  <= ra_sub;
                sa_reg  <= sa_add;
                d_reg   <= d_reg >> 1;
                sd_reg  <= sd_reg >> 1;
                cnt_reg <= cnt_reg - CNT_BITS'(1);
            end else if (cmd.euclid) begin
                // close the quotient: rotate remainders and cofactors
                ra_reg  <= rb_reg;
                rb_reg  <= ra_sub;
                sa_reg  <= sb_reg;
                sb_reg  <= sa_add;
                d_reg   <= ra_sub;
                sd_reg  <= sa_add;
                odd_reg <= ~odd_reg;
            end else begin
                x_reg <= ra_sub;
            end
        end else if (cmd.prep) begin
            w_reg   <= dir_val;
            bad_reg <= !bypass && p_small;
            ra_reg  <= p_reg;
            rb_reg  <= inv_arg;
            sa_reg  <= '0;
            sb_reg  <= root_t'(1);
            d_reg   <= inv_arg;
            sd_reg  <= root_t'(1);
            cnt_reg <= '0;
            odd_reg <= 1'b0;
        end else if (cmd.fin) begin
            w_reg <= alu_res;
            if (cmd.mop == MOP_SIGN) begin
                iv_reg <= sign_val;
            end
            if (cmd.mop == MOP_FIX) begin
                bad_reg <= (ra_reg != root_t'(1));
            end
        end else if (cmd.out_load) begin
            img_out_reg   <= bad_reg ? '0 : w_reg;
            order_out_reg <= order_of(m);
            bad_out_reg   <= bad_reg;
        end
    end

    assign image_root     = img_out_reg;
    assign orbit_order    = order_out_reg;
    assign not_invertible = bad_out_reg;

    a_cnt_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.align && shift_ok |-> cnt_reg != CNT_MAX)
        else $error("divisor shift count wrapped");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sub |-> d_reg != '0)
        else $error("subtract step with zero divisor");

    a_work_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin && cmd.mop != MOP_FIX |-> w_reg < p_reg)
        else $error("work register not reduced below modulus");

endmodule

// File: rtl/grm_ctrl.sv
module grm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           mode,
    input  logic                 root_valid,
    output logic                 root_ready,
    output logic                 image_valid,
    input  logic                 image_ready,
    input  grm_pkg::grm_status_t st,
    output grm_pkg::grm_cmd_t    cmd
);
    import grm_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CHECK  = 9'b000000010,
        ST_RALIGN = 9'b000000100,
        ST_RSUB   = 9'b000001000,
        ST_PREP   = 9'b000010000,
        ST_ALIGN  = 9'b000100000,
        ST_SUB    = 9'b001000000,
        ST_FIN    = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.mop    = fin_op(mode_t'(mode), step_reg);
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (root_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = st.need_reduce ? ST_RALIGN : ST_PREP;
            end
            ST_RALIGN:
            begin
                cmd.align = 1'b1;
                if (!st.shift_ok) state_next = ST_RSUB;
            end
            ST_RSUB:
            begin
                cmd.sub = 1'b1;
                if (st.last) state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = st.direct ? ST_DONE : ST_ALIGN;
            end
            ST_ALIGN:
            begin
                cmd.align = 1'b1;
                if (!st.shift_ok) state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                cmd.euclid = 1'b1;
                if (st.last) begin
                    if (st.rem_zero) begin
                        state_next = ST_FIN;
                        step_next  = '0;
                    end else begin
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_FIN:
            begin
                if (cmd.mop == MOP_END) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.fin   = 1'b1;
                    step_next = step_reg + STEP_BITS'(1);
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || image_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !image_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign root_ready  = (state_reg == ST_IDLE);
    assign image_valid = out_valid_reg;

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_ready |=> state_reg == ST_CHECK)
        else $error("accepted word did not start processing");

    a_gcd_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUB && st.last && st.rem_zero |=> state_reg == ST_FIN && step_reg == '0)
        else $error("gcd loop did not enter finishing ops");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("output word raised outside done state");

endmodule

// File: rtl/galois_root_map.sv
// Maps a projective root r mod p (r == p is infinity) through the fractional-linear
// map chosen by action_mode and returns the image, the map's order and a flag for a
// missing inverse. One word is in flight at a time; the next root is taken while the
// previous result waits in the output register. Run time depends on a shared
// shift-subtract divider: pole, infinity, identity and negate cases skip the gcd
// loop; a root above the modulus adds a reduction that grows with the bit length
// difference; an inverse adds an align and subtract pass per Euclid quotient, each
// growing with the quotient's bit length, plus the finishing ops. action_mode
// resets to identity.
module galois_root_map (
    input  logic               clk,
    input  logic               rst_n,
    grm_root_if.sink           roots,
    grm_image_if.source        images,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_wr_data
);
    import grm_pkg::*;

    logic [2:0]  action_mode_reg;
    grm_cmd_t    cmd;
    grm_status_t st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            action_mode_reg <= MODE_IDENT;
        end else if (cfg_wr_en) begin
            action_mode_reg <= cfg_wr_data;
        end
    end

    grm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (action_mode_reg),
        .root_valid  (roots.valid),
        .root_ready  (roots.ready),
        .image_valid (images.valid),
        .image_ready (images.ready),
        .st          (st),
        .cmd         (cmd)
    );

    grm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .root           (roots.root),
        .modulus        (roots.modulus),
        .mode           (action_mode_reg),
        .cmd            (cmd),
        .st             (st),
        .image_root     (images.image_root),
        .orbit_order    (images.orbit_order),
        .not_invertible (images.not_invertible)
    );

endmodule
